// ----- design/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants for the RGB to HSL converter
// Channel width, divider lane layout and the word handed along the cell chain.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int FULL         = (1 << CHANNEL_BITS) - 1;

    // result field widths
    localparam int HUE_W = 9;
    localparam int PCT_W = 7;

    // divider geometry: one quotient bit per cell, HUE_W cells
    localparam int Q_W       = HUE_W;
    localparam int DEN_W     = CHANNEL_BITS + 1;
    localparam int NUM_W     = DEN_W + Q_W;
    localparam int NUM_CELLS = Q_W;

    // lightness = 50*sum/FULL as (50*sum * ceil(2^SHIFT/FULL)) >> SHIFT;
    // the shift keeps the rounding error below 1/FULL for sum <= 2*FULL
    localparam int     LIGHT_SHIFT  = 2 * CHANNEL_BITS + 7;
    localparam longint LIGHT_RECIP  = ((longint'(1) << LIGHT_SHIFT) + FULL - 1) / FULL;
    localparam int     LIGHT_PROD_W = NUM_W + LIGHT_SHIFT - CHANNEL_BITS + 1;

    localparam int S_TDATA_W = ((3 * CHANNEL_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((HUE_W + 2 * PCT_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - HUE_W - 2 * PCT_W;

    localparam logic [HUE_W-1:0] HUE_WRAP = HUE_W'(360);

    // one restoring-division lane: divisor, partial remainder, and a
    // shift register that feeds numerator bits out and quotient bits in
    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] pr;
        logic [Q_W-1:0]   nq;
    } div_lane_t;

    typedef struct packed {
        logic             grey;
        logic             red_neg;
        div_lane_t        hue;
        div_lane_t        sat;
        logic [PCT_W-1:0] light;
    } cell_word_t;

    // numerator must satisfy num < den * 2^Q_W
    function automatic div_lane_t make_lane(logic [NUM_W-1:0] num, logic [DEN_W-1:0] den);
        div_lane_t lane;
        lane.den = den;
        lane.pr  = num[NUM_W-1:Q_W];
        lane.nq  = num[Q_W-1:0];
        return lane;
    endfunction

endpackage

// ----- design/rgb_to_hsl_converter_core.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_core: streaming RGB to HSL pixel converter
// Takes one RGB word per clock while the output is not stalled and returns hue, saturation and lightness.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock and returns one result word per pixel, in
// order, after a setup stage (max/min, sector pick, dividends, lightness
// by reciprocal multiplication), nine division cells that each retire one
// quotient bit of the hue and saturation quotients, and the output register.
// Sustained rate is one word per cycle while m_tready
// stays high. When the output stalls the whole chain holds, and a one-word
// skid register still takes the word offered in that cycle. Hue is in whole
// degrees (0..359), saturation and lightness in whole percent, all truncated;
// grey pixels give hue and saturation of zero.
module rgb_to_hsl_converter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [rhc_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hue [8:0], saturation [15:9], lightness [22:16], zero [23]
    output logic [rhc_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int CB        = rhc_pkg::CHANNEL_BITS;
    localparam int NUM_CELLS = rhc_pkg::NUM_CELLS;

    logic                            skid_valid_reg;
    logic                            skid_valid_next;
    logic [rhc_pkg::S_TDATA_W-1:0]   skid_data_reg;
    logic [rhc_pkg::S_TDATA_W-1:0]   src_data;
    logic                            src_valid;
    logic                            pipe_en;

    logic                            chain_valid [0:NUM_CELLS];
    rhc_pkg::cell_word_t             chain_word  [0:NUM_CELLS];

    logic [rhc_pkg::HUE_W-1:0]       hue;
    logic [rhc_pkg::PCT_W-1:0]       saturation;
    logic [rhc_pkg::PCT_W-1:0]       lightness;

    assign pipe_en   = !m_tvalid || m_tready;
    assign s_tready  = !skid_valid_reg;
    assign src_valid = skid_valid_reg || s_tvalid;
    assign src_data  = skid_valid_reg ? skid_data_reg : s_tdata;

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (pipe_en)
        begin
            skid_valid_next = 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    // park the word that arrives while the chain is held
    always_ff @(posedge clk)
    begin
        if (!pipe_en && s_tvalid && s_tready)
        begin
            skid_data_reg <= s_tdata;
        end
    end

    rhc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (src_valid),
        .red       (src_data[CB-1:0]),
        .green     (src_data[2*CB-1:CB]),
        .blue      (src_data[3*CB-1:2*CB]),
        .out_valid (chain_valid[0]),
        .out_word  (chain_word[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        rhc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (chain_valid[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    rhc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .in_valid   (chain_valid[NUM_CELLS]),
        .in_word    (chain_word[NUM_CELLS]),
        .out_valid  (m_tvalid),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness)
    );

    assign m_tdata = {{rhc_pkg::M_PAD_W{1'b0}}, lightness, saturation, hue};

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (hue < rhc_pkg::HUE_WRAP))
        else $error("hue out of range");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (saturation <= 7'd100 && lightness <= 7'd100))
        else $error("percent field out of range");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !pipe_en) |=> !s_tready)
        else $error("skid word not held");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pipe_en) |=> s_tready)
        else $error("skid word not drained");

endmodule

// ----- design/rhc_front.sv -----
// ----------------------------------------------------------------------------
// rhc_front: pixel setup stage
// Finds max/min, picks the hue sector, builds the hue and saturation
// dividends/divisors and computes lightness.
// ----------------------------------------------------------------------------
module rhc_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [rhc_pkg::CHANNEL_BITS-1:0]   red,
    input  logic [rhc_pkg::CHANNEL_BITS-1:0]   green,
    input  logic [rhc_pkg::CHANNEL_BITS-1:0]   blue,
    output logic                               out_valid,
    output rhc_pkg::cell_word_t                out_word
);

    localparam int CB     = rhc_pkg::CHANNEL_BITS;
    localparam int NUM_W  = rhc_pkg::NUM_W;
    localparam int DEN_W  = rhc_pkg::DEN_W;
    localparam int PROD_W = rhc_pkg::LIGHT_PROD_W;

    logic [CB-1:0]       hi;
    logic [CB-1:0]       lo;
    logic [DEN_W-1:0]    sum;
    logic [CB-1:0]       spread;
    logic [NUM_W-1:0]    hue_num;
    logic                red_neg;
    logic [DEN_W-1:0]    sat_den;
    logic [PROD_W-1:0]   light_prod;
    rhc_pkg::cell_word_t word_next;
    rhc_pkg::cell_word_t word_reg;
    logic                valid_reg;

    always_comb
    begin
        hi = red;
        if (green > hi) hi = green;
        if (blue > hi)  hi = blue;
        lo = red;
        if (green < lo) lo = green;
        if (blue < lo)  lo = blue;

        sum    = DEN_W'(hi) + DEN_W'(lo);
        spread = hi - lo;

        red_neg = 1'b0;
        // blue wins ties over green, green over red
        if (blue == hi)
        begin
            hue_num = NUM_W'(60) * NUM_W'(red) + NUM_W'(240) * NUM_W'(spread)
                    - NUM_W'(60) * NUM_W'(green);
        end
        else if (green == hi)
        begin
            hue_num = NUM_W'(60) * NUM_W'(blue) + NUM_W'(120) * NUM_W'(spread)
                    - NUM_W'(60) * NUM_W'(red);
        end
        else
        begin
            // divide the magnitude, fix the sign at the back end
            red_neg = green < blue;
            hue_num = red_neg ? NUM_W'(60) * NUM_W'(blue - green)
                              : NUM_W'(60) * NUM_W'(green - blue);
        end

        // lightness < 50 exactly when sum < FULL
        sat_den = (sum < DEN_W'(rhc_pkg::FULL)) ? sum
                                                : DEN_W'(2 * rhc_pkg::FULL) - sum;

        // divide by FULL through the reciprocal
        light_prod = PROD_W'(NUM_W'(50) * NUM_W'(sum)) * PROD_W'(rhc_pkg::LIGHT_RECIP);

        word_next.grey    = (spread == '0);
        word_next.red_neg = red_neg;
        word_next.hue     = rhc_pkg::make_lane(hue_num, DEN_W'(spread));
        word_next.sat     = rhc_pkg::make_lane(NUM_W'(100) * NUM_W'(spread), sat_den);
        word_next.light   = light_prod[rhc_pkg::LIGHT_SHIFT +: rhc_pkg::PCT_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ----- design/rhc_cell.sv -----
// ----------------------------------------------------------------------------
// rhc_cell: one restoring-division step for the hue and saturation lanes
// Shifts one numerator bit into each remainder and produces one quotient bit.
// ----------------------------------------------------------------------------
module rhc_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  rhc_pkg::cell_word_t in_word,
    output logic                out_valid,
    output rhc_pkg::cell_word_t out_word
);

    localparam int DEN_W = rhc_pkg::DEN_W;
    localparam int Q_W   = rhc_pkg::Q_W;

    function automatic rhc_pkg::div_lane_t step(rhc_pkg::div_lane_t lane);
        rhc_pkg::div_lane_t res;
        logic [DEN_W:0]     pr2;
        logic [DEN_W:0]     diff;
        logic               ge;
        pr2  = {lane.pr, lane.nq[Q_W-1]};
        diff = pr2 - {1'b0, lane.den};
        ge   = pr2 >= {1'b0, lane.den};
        res.den = lane.den;
        res.pr  = ge ? diff[DEN_W-1:0] : pr2[DEN_W-1:0];
        res.nq  = {lane.nq[Q_W-2:0], ge};
        return res;
    endfunction

    rhc_pkg::cell_word_t word_next;
    rhc_pkg::cell_word_t word_reg;
    logic                valid_reg;

    always_comb
    begin
        word_next         = in_word;
        word_next.hue     = step(in_word.hue);
        word_next.sat     = step(in_word.sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ----- design/rhc_back.sv -----
// ----------------------------------------------------------------------------
// rhc_back: result finishing and output register
// Wraps negative red-sector hue, forces grey pixels, holds the output word.
// ----------------------------------------------------------------------------
module rhc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  rhc_pkg::cell_word_t           in_word,
    output logic                          out_valid,
    output logic [rhc_pkg::HUE_W-1:0]     hue,
    output logic [rhc_pkg::PCT_W-1:0]     saturation,
    output logic [rhc_pkg::PCT_W-1:0]     lightness
);

    localparam int HUE_W = rhc_pkg::HUE_W;
    localparam int PCT_W = rhc_pkg::PCT_W;

    logic [HUE_W-1:0] hq;
    logic [HUE_W-1:0] hue_next;
    logic [PCT_W-1:0] sat_next;
    logic [PCT_W-1:0] light_next;
    logic [HUE_W-1:0] hue_reg;
    logic [PCT_W-1:0] sat_reg;
    logic [PCT_W-1:0] light_reg;
    logic             valid_reg;

    always_comb
    begin
        hq = in_word.hue.nq[HUE_W-1:0];
        if (in_word.grey)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            // negative quotient that truncated to zero stays zero
            hue_next = (in_word.red_neg && hq != '0) ? rhc_pkg::HUE_WRAP - hq : hq;
            sat_next = in_word.sat.nq[PCT_W-1:0];
        end
        light_next = in_word.light;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            light_reg <= light_next;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = light_reg;

endmodule
